### rtl/ibus_pkg.sv
`default_nettype none

package ibus_pkg;

	// Number of channels carried in one frame.
	localparam int CHANNELS = 14;

	// Two header bytes, two bytes per channel, two trailer bytes.
	localparam int FRAME_LEN   = 2 + 2 * CHANNELS + 2;
	localparam int TRAILER_POS = 2 + 2 * CHANNELS;

	localparam int COUNT_W = 6;
	localparam int CHAN_W  = 10;
	localparam int CMD_W   = 11;
	localparam int SW_W    = 6;
	localparam int SLOTS   = 6;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Channel number (counting from zero) held in each kept slot.
	localparam logic [4:0] SLOT_CHANNEL [SLOTS] = '{5'd0, 5'd1, 5'd6, 5'd7, 5'd8, 5'd9};

	localparam logic [15:0] CHECK_BASE  = 16'hFFFF;
	localparam logic [15:0] RAW_LOW     = 16'd1000;
	localparam logic [15:0] RAW_HIGH    = 16'd2000;
	localparam logic [CHAN_W-1:0] CHAN_FULL   = 10'd1000;
	localparam logic [CHAN_W-1:0] SW_HIGH_LIM = 10'd850;
	localparam logic [CHAN_W-1:0] SW_MID_LIM  = 10'd250;
	localparam logic [CMD_W-1:0]  CMD_CENTRE  = 11'd500;

	localparam logic [15:0] RST_TIMEOUT_LIMIT = 16'd160;
	localparam logic [7:0]  RST_LENGTH_BYTE   = 8'd32;
	localparam logic [7:0]  RST_COMMAND_BYTE  = 8'd64;

	typedef enum logic [1:0] {
		FUNC_BYTE = 2'd0,
		FUNC_IDLE = 2'd1,
		FUNC_TICK = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT_LIMIT = 2'd0,
		REG_LENGTH_BYTE   = 2'd1,
		REG_COMMAND_BYTE  = 2'd2
	} reg_idx_t;

	typedef logic [SLOTS-1:0][CHAN_W-1:0] chan_arr_t;

	// What the byte parser hands to the top level for the word in stage one.
	typedef struct packed {
		logic      frame_ok;
		chan_arr_t chans;
	} frame_info_t;

	function automatic logic [CHAN_W-1:0] clamp_channel(input logic [15:0] raw);
		logic [15:0] diff;
		diff = raw - RAW_LOW;
		if (raw < RAW_LOW)
			return '0;
		else if (raw > RAW_HIGH)
			return CHAN_FULL;
		else
			return diff[CHAN_W-1:0];
	endfunction

	function automatic logic sw_two(input logic [CHAN_W-1:0] v);
		return v > SW_HIGH_LIM;
	endfunction

	function automatic logic [1:0] sw_three(input logic [CHAN_W-1:0] v);
		if (v > SW_HIGH_LIM)
			return 2'd2;
		else if (v > SW_MID_LIM)
			return 2'd1;
		else
			return 2'd0;
	endfunction

	// (v - 500) * 2, kept to the command width.
	function automatic logic [CMD_W-1:0] to_cmd(input logic [CHAN_W-1:0] v);
		logic [CMD_W-1:0] diff;
		diff = {1'b0, v} - CMD_CENTRE;
		return {diff[CMD_W-2:0], 1'b0};
	endfunction

endpackage

`default_nettype wire

### rtl/ibus_parser.sv
`default_nettype none

module ibus_parser
	import ibus_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  length_byte,
	input  wire logic [7:0]  command_byte,
	output frame_info_t      info
);

	logic [COUNT_W-1:0] burst_count_q, burst_count_d;
	logic [15:0]        running_sum_q, running_sum_d;
	logic [7:0]         low_byte_q, low_byte_d;
	logic               header_match_q, header_match_d;
	chan_arr_t          pending_q;
	logic [SLOTS-1:0]   pend_we;
	logic [COUNT_W-1:0] ch_pos;
	logic [4:0]         ch_idx;
	logic [CHAN_W-1:0]  chan_value;
	logic [15:0]        trailer;

	assign ch_pos     = burst_count_q - COUNT_W'(2);
	assign ch_idx     = ch_pos[COUNT_W-1:1];
	assign chan_value = clamp_channel({rx_byte, low_byte_q});
	assign trailer    = {rx_byte, low_byte_q};

	assign info.frame_ok = (burst_count_q == COUNT_W'(FRAME_LEN)) && header_match_q;
	assign info.chans    = pending_q;

	always_comb begin
		burst_count_d  = burst_count_q;
		running_sum_d  = running_sum_q;
		low_byte_d     = low_byte_q;
		header_match_d = header_match_q;
		pend_we        = '0;
		unique case (func_t'(func))
			FUNC_BYTE: begin
				if (burst_count_q != COUNT_MAX)
					burst_count_d = burst_count_q + COUNT_W'(1);
				if (burst_count_q == '0) begin
					header_match_d = (rx_byte == length_byte);
					running_sum_d  = {8'd0, rx_byte};
				end else if (burst_count_q < COUNT_W'(TRAILER_POS)) begin
					running_sum_d = running_sum_q + {8'd0, rx_byte};
					if (burst_count_q == COUNT_W'(1)) begin
						header_match_d = header_match_q && (rx_byte == command_byte);
					end else if (!burst_count_q[0]) begin
						low_byte_d = rx_byte;
					end else begin
						for (int s = 0; s < SLOTS; s++)
							pend_we[s] = (ch_idx == SLOT_CHANNEL[s]);
					end
				end else if (burst_count_q == COUNT_W'(TRAILER_POS)) begin
					low_byte_d = rx_byte;
				end else if (burst_count_q == COUNT_W'(TRAILER_POS + 1)) begin
					header_match_d = header_match_q &&
						(trailer == (CHECK_BASE - running_sum_q));
				end
			end
			FUNC_IDLE: begin
				burst_count_d  = '0;
				running_sum_d  = '0;
				header_match_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_count_q  <= '0;
			running_sum_q  <= '0;
			low_byte_q     <= '0;
			header_match_q <= 1'b0;
		end else if (advance) begin
			burst_count_q  <= burst_count_d;
			running_sum_q  <= running_sum_d;
			low_byte_q     <= low_byte_d;
			header_match_q <= header_match_d;
		end
	end

	// Channel values of the burst in progress; every entry is written before
	// a frame that uses it can be accepted.
	always_ff @(posedge clk) begin
		for (int s = 0; s < SLOTS; s++)
			if (advance && pend_we[s])
				pending_q[s] <= chan_value;
	end

endmodule

`default_nettype wire

### rtl/ibus_frame_receiver_top.sv
// Receiver for a serial channel frame: bytes, idle marks and ticks in, one result word out.
// An accepted word waits in stage one, then moves into the result registers.
// Throughput: one word per cycle while the consumer keeps up, one register stage per side.
// Reset (arst_n low, asynchronous) clears all control state, the counters, commands
// and switch word, and restores the configuration registers to their default values.
`default_nettype none

module ibus_frame_receiver_top
	import ibus_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Input channel.
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        func,
	input  wire logic [7:0]        rx_byte,
	// Output channel.
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [CMD_W-1:0] cmd_one,
	output logic signed [CMD_W-1:0] cmd_two,
	output logic [SW_W-1:0]        switch_bits,
	output logic                   timed_out,
	output logic                   frame_accepted,
	// Configuration port.
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// Configuration registers.
	logic [15:0] timeout_limit_q;
	logic [7:0]  length_byte_q;
	logic [7:0]  command_byte_q;
	logic        cfg_write;

	// Stage one holds the accepted word until the result register is free.
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	// Block state that is also the result word.
	chan_arr_t          active_q;
	logic [15:0]        timeout_count_q;
	logic               timeout_flag_q;
	logic [CMD_W-1:0]   cmd_one_q, cmd_one_d;
	logic [CMD_W-1:0]   cmd_two_q, cmd_two_d;
	logic [SW_W-1:0]    switch_q, switch_d;
	logic [15:0]        timeout_count_d;
	logic               timeout_flag_d;
	logic               out_valid_q;
	logic               accepted_q;
	logic               frame_take;
	frame_info_t        info;

	// ------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is
	// tied high so no wait states are ever inserted.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= RST_TIMEOUT_LIMIT;
			length_byte_q   <= RST_LENGTH_BYTE;
			command_byte_q  <= RST_COMMAND_BYTE;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_TIMEOUT_LIMIT: timeout_limit_q <= pwdata[15:0];
				REG_LENGTH_BYTE:   length_byte_q   <= pwdata[7:0];
				REG_COMMAND_BYTE:  command_byte_q  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TIMEOUT_LIMIT: prdata = {16'd0, timeout_limit_q};
			REG_LENGTH_BYTE:   prdata = {24'd0, length_byte_q};
			REG_COMMAND_BYTE:  prdata = {24'd0, command_byte_q};
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshake. A word in stage one moves on whenever the result register
	// is empty or being emptied in the same cycle, so a new word can enter
	// every cycle while the consumer keeps up.
	// ------------------------------------------------------------------
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			byte_s1 <= rx_byte;
		end
	end

	// Byte assembly, header and checksum tracking.
	ibus_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.func         (func_s1),
		.rx_byte      (byte_s1),
		.length_byte  (length_byte_q),
		.command_byte (command_byte_q),
		.info         (info)
	);

	// ------------------------------------------------------------------
	// Frame acceptance, tick handling and the timeout counter.
	// ------------------------------------------------------------------
	assign frame_take = (func_t'(func_s1) == FUNC_IDLE) && info.frame_ok;

	always_comb begin
		cmd_one_d       = cmd_one_q;
		cmd_two_d       = cmd_two_q;
		switch_d        = switch_q;
		timeout_count_d = timeout_count_q;
		timeout_flag_d  = timeout_flag_q;
		unique case (func_t'(func_s1))
			FUNC_IDLE: begin
				if (info.frame_ok) begin
					timeout_count_d = '0;
					timeout_flag_d  = 1'b0;
				end
			end
			FUNC_TICK: begin
				// Commands follow the channels only while the link is alive.
				if (!timeout_flag_q) begin
					cmd_one_d = to_cmd(active_q[0]);
					cmd_two_d = to_cmd(active_q[1]);
					switch_d  = {sw_two(active_q[5]), sw_three(active_q[4]),
						sw_three(active_q[3]), sw_two(active_q[2])};
				end
				// The counter compares its old value and stops at the limit;
				// expiry zeroes the commands and drops the first switch bit.
				if (timeout_count_q >= timeout_limit_q) begin
					timeout_flag_d  = 1'b1;
					timeout_count_d = timeout_limit_q;
					cmd_one_d       = '0;
					cmd_two_d       = '0;
					switch_d[0]     = 1'b0;
				end else begin
					timeout_count_d = timeout_count_q + 16'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= '0;
			timeout_count_q <= '0;
			timeout_flag_q  <= 1'b0;
			cmd_one_q       <= '0;
			cmd_two_q       <= '0;
			switch_q        <= '0;
			accepted_q      <= 1'b0;
		end else if (advance) begin
			if (frame_take)
				active_q <= info.chans;
			timeout_count_q <= timeout_count_d;
			timeout_flag_q  <= timeout_flag_d;
			cmd_one_q       <= cmd_one_d;
			cmd_two_q       <= cmd_two_d;
			switch_q        <= switch_d;
			accepted_q      <= frame_take;
		end
	end

	// The state registers double as the result register: they only change
	// when a word advances, which needs the previous result to be taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign cmd_one        = signed'(cmd_one_q);
	assign cmd_two        = signed'(cmd_two_q);
	assign switch_bits    = switch_q;
	assign timed_out      = timeout_flag_q;
	assign frame_accepted = accepted_q;

endmodule

`default_nettype wire

### tb/sv/ibus_frame_receiver_top_tb.sv
module ibus_frame_receiver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ibus_pkg::*;

	// Random words after the directed part, the settling pause after the last result word,
	// and the cycle count at which a stuck run is abandoned.
	localparam int RANDOM_WORDS = 800;
	localparam int SETTLE       = 6;
	localparam int CYCLE_LIMIT  = 1_000_000;

	// The one value of func that the block leaves without meaning.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// One result word as the block reports it.
	typedef struct packed {
		logic signed [CMD_W-1:0] cmd_one;
		logic signed [CMD_W-1:0] cmd_two;
		logic [SW_W-1:0]         switch_bits;
		logic                    timed_out;
		logic                    frame_accepted;
	} status_t;

	// Results that can be read straight off the frame layout. Before any frame every channel is
	// zero, so the commands sit at full reverse. A frame of all 2000 puts every channel at full
	// scale: commands at full forward, both two-position switches up and both three-position
	// switches in their top position.
	localparam status_t AT_RESET       = '{-11'sd1000, -11'sd1000, 6'd0, 1'b0, 1'b0};
	localparam status_t FIRST_FRAME_IN = '{-11'sd1000, -11'sd1000, 6'd0, 1'b0, 1'b1};
	localparam status_t FULL_SCALE     = '{11'sd1000, 11'sd1000, 6'd53, 1'b0, 1'b0};
	localparam status_t FULL_HELD_IN   = '{11'sd1000, 11'sd1000, 6'd53, 1'b0, 1'b1};

	typedef enum logic [1:0] {
		STEP_WORD,
		STEP_FRAME,
		STEP_CFG
	} step_kind_t;

	// Ways of spoiling a frame so that the block must turn it away.
	typedef enum logic [2:0] {
		FLAW_NONE,
		FLAW_HEADER,
		FLAW_COMMAND,
		FLAW_CHECKSUM,
		FLAW_SHORT,
		FLAW_LONG
	} frame_flaw_t;

	// One row of the directed plan. For a word, code is the func value and value holds the byte;
	// for a frame, value is the raw reading put on every channel; for a register write, code is
	// the register and value the data.
	typedef struct packed {
		step_kind_t  kind;
		logic [1:0]  code;
		logic [15:0] value;
		frame_flaw_t flaw;
		logic        typed;
		status_t     want;
	} step_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              func;
	logic [7:0]              rx_byte;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [CMD_W-1:0] cmd_one;
	logic signed [CMD_W-1:0] cmd_two;
	logic [SW_W-1:0]         switch_bits;
	logic                    timed_out;
	logic                    frame_accepted;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [3:0]              paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;

	ibus_frame_receiver_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cmd_one        (cmd_one),
		.cmd_two        (cmd_two),
		.switch_bits    (switch_bits),
		.timed_out      (timed_out),
		.frame_accepted (frame_accepted),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// Our own copy of the receiver. The settings mirror the three registers; the rest follows
	// the parser, the kept channels, the timeout counter and the outputs driven by ticks.
	logic [15:0]       lost_after;
	logic [7:0]        want_length;
	logic [7:0]        want_command;
	logic [COUNT_W-1:0] frame_pos;
	logic [15:0]       byte_sum;
	logic [7:0]        low_half;
	logic              frame_good;
	logic [CHAN_W-1:0] staged_chan [SLOTS];
	logic [CHAN_W-1:0] live_chan [SLOTS];
	logic [15:0]       tick_count;
	logic              link_lost;
	logic [CMD_W-1:0]  cmd_one_now;
	logic [CMD_W-1:0]  cmd_two_now;
	logic [SW_W-1:0]   switch_now;

	status_t status_due [$];
	step_t   dir_plan [$];
	int      words_sent;
	int      mismatches;
	int      cycles;
	bit      tx_gaps_on;
	bit      rx_stalls_on;

	function automatic logic signed [CMD_W-1:0] command_of(input logic [CHAN_W-1:0] v);
		return CMD_W'((int'(v) - int'(CMD_CENTRE)) * 2);
	endfunction

	function automatic logic lever_two(input logic [CHAN_W-1:0] v);
		return v > SW_HIGH_LIM;
	endfunction

	function automatic logic [1:0] lever_three(input logic [CHAN_W-1:0] v);
		if (v > SW_HIGH_LIM)
			return 2'd2;
		if (v > SW_MID_LIM)
			return 2'd1;
		return 2'd0;
	endfunction

	// Advances the copy of the receiver by one accepted word and returns the result word it
	// should produce.
	function automatic status_t next_status(input logic [1:0] f, input logic [7:0] b);
		status_t            r;
		logic [COUNT_W-1:0] pos;
		logic [15:0]        reading;
		int                 chan;
		logic               took;
		took = 1'b0;
		case (f)
			FUNC_BYTE: begin
				pos = frame_pos;
				if (frame_pos != COUNT_MAX)
					frame_pos++;
				if (pos >= FRAME_LEN) begin
					// Past the end of a frame: only the count moves.
				end else if (pos == 0) begin
					frame_good = (b == want_length);
					byte_sum = 16'(b);
				end else if (pos < TRAILER_POS) begin
					byte_sum += 16'(b);
					if (pos == 1) begin
						frame_good = frame_good && (b == want_command);
					end else if (!pos[0]) begin
						low_half = b;
					end else begin
						chan = (int'(pos) - 2) >> 1;
						reading = {b, low_half};
						for (int s = 0; s < SLOTS; s++) begin
							if (int'(SLOT_CHANNEL[s]) == chan) begin
								if (reading < RAW_LOW)
									staged_chan[s] = '0;
								else if (reading > RAW_HIGH)
									staged_chan[s] = CHAN_FULL;
								else
									staged_chan[s] = CHAN_W'(reading - RAW_LOW);
							end
						end
					end
				end else if (pos == TRAILER_POS) begin
					low_half = b;
				end else begin
					frame_good = frame_good && ({b, low_half} == CHECK_BASE - byte_sum);
				end
			end
			FUNC_IDLE: begin
				took = (frame_pos == FRAME_LEN) && frame_good;
				if (took) begin
					live_chan = staged_chan;
					tick_count = '0;
					link_lost = 1'b0;
				end
				frame_pos = '0;
				byte_sum = '0;
				frame_good = 1'b0;
			end
			FUNC_TICK: begin
				if (!link_lost) begin
					cmd_one_now = command_of(live_chan[0]);
					cmd_two_now = command_of(live_chan[1]);
					switch_now = {lever_two(live_chan[5]), lever_three(live_chan[4]),
						lever_three(live_chan[3]), lever_two(live_chan[2])};
				end
				if (tick_count >= lost_after) begin
					link_lost = 1'b1;
					tick_count = lost_after;
					cmd_one_now = '0;
					cmd_two_now = '0;
					switch_now[0] = 1'b0;
				end else begin
					tick_count++;
				end
			end
			default: begin
				// The unused func value leaves everything as it is.
			end
		endcase
		r.cmd_one = cmd_one_now;
		r.cmd_two = cmd_two_now;
		r.switch_bits = switch_now;
		r.timed_out = link_lost;
		r.frame_accepted = took;
		return r;
	endfunction

	// Gap lengths for both sides: mostly none or short, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Raw channel readings weighted towards the clamp limits and the switch thresholds.
	function automatic logic [15:0] random_raw();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 999));
			1: return RAW_LOW;
			2: return RAW_HIGH;
			3: return 16'($urandom_range(2001, 65535));
			4: return 16'd1250 + 16'($urandom_range(0, 1)) + ($urandom_range(0, 1) ? 16'd600 : 16'd0);
			default: return 16'($urandom_range(1000, 2000));
		endcase
	endfunction

	function automatic void add_step(input step_kind_t kind, input logic [1:0] code,
			input logic [15:0] value, input frame_flaw_t flaw = FLAW_NONE,
			input logic typed = 1'b0, input status_t want = '0);
		step_t s;
		s.kind = kind;
		s.code = code;
		s.value = value;
		s.flaw = flaw;
		s.typed = typed;
		s.want = want;
		dir_plan.push_back(s);
	endfunction

	// Offers one word after a random gap and holds it until the block takes it. On the edge that
	// takes it, the expected result word is queued: the typed one where a row gives it, else the
	// copy's own. The copy is advanced either way so that it stays in step with the block.
	task automatic send_word(input logic [1:0] f, input logic [7:0] b,
			input logic typed = 1'b0, input status_t want = '0);
		status_t predicted;
		repeat (tx_gaps_on ? gap_length() : 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		rx_byte <= b;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predicted = next_status(f, b);
		status_due.push_back(typed ? want : predicted);
		if (f != FUNC_UNUSED)
			words_sent++;
	endtask

	// Builds a frame for the header bytes now in force, spoils it as asked, and sends its bytes.
	// The idle mark that closes it is left to the caller.
	task automatic send_frame(input logic [CHANNELS-1:0][15:0] raw, input frame_flaw_t flaw);
		logic [7:0]  burst [$];
		logic [15:0] sum;
		logic [15:0] trailer;
		int          c;
		burst.push_back(flaw == FLAW_HEADER ? ~want_length : want_length);
		burst.push_back(flaw == FLAW_COMMAND ? ~want_command : want_command);
		for (c = 0; c < CHANNELS; c++) begin
			burst.push_back(raw[c][7:0]);
			burst.push_back(raw[c][15:8]);
		end
		sum = '0;
		foreach (burst[i])
			sum += 16'(burst[i]);
		trailer = CHECK_BASE - sum;
		if (flaw == FLAW_CHECKSUM)
			trailer ^= 16'd1 << $urandom_range(0, 15);
		burst.push_back(trailer[7:0]);
		burst.push_back(trailer[15:8]);
		if (flaw == FLAW_SHORT)
			repeat ($urandom_range(1, 6))
				void'(burst.pop_back());
		// Up to forty extra bytes, so that the byte count also reaches its ceiling.
		if (flaw == FLAW_LONG)
			repeat ($urandom_range(1, 40))
				burst.push_back(8'($urandom));
		foreach (burst[i])
			send_word(FUNC_BYTE, burst[i]);
	endtask

	// Stops offering words and waits until every expected result word has come back, then lets
	// the pipeline settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	// A register write: setup cycle, then access cycle until pready. It is only issued with the
	// block idle, so the copy takes the new value at once.
	task automatic write_register(input reg_idx_t idx, input logic [15:0] v);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TIMEOUT_LIMIT: lost_after = v;
			REG_LENGTH_BYTE:   want_length = v[7:0];
			REG_COMMAND_BYTE:  want_command = v[7:0];
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The result side stalls at random while stalls are switched on, and takes every word
	// otherwise.
	initial begin
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (rx_stalls_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				hold = gap_length();
			end else begin
				out_ready <= 1'b1;
				hold = $urandom_range(0, 6);
			end
		end
	end

	// Every result word taken is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		status_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (status_due.size() == 0) begin
				$display("%0t: result word with nothing expected, actual %0d %0d %0d %0d %0d",
					$time, cmd_one, cmd_two, switch_bits, timed_out, frame_accepted);
				mismatches++;
			end else begin
				want = status_due.pop_front();
				compare_field("cmd_one", want.cmd_one, cmd_one);
				compare_field("cmd_two", want.cmd_two, cmd_two);
				compare_field("switch_bits", want.switch_bits, switch_bits);
				compare_field("timed_out", want.timed_out, timed_out);
				compare_field("frame_accepted", want.frame_accepted, frame_accepted);
			end
		end
	end

	// Watchdog, and the occasional switch between gappy and steady traffic on either side, so
	// that long stretches with no gaps at all occur too.
	always @(posedge clk) begin
		cycles++;
		if ($urandom_range(0, 399) == 0)
			tx_gaps_on = !tx_gaps_on;
		if ($urandom_range(0, 399) == 0)
			rx_stalls_on = !rx_stalls_on;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run abandoned with %0d result words outstanding",
				$time, status_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [CHANNELS-1:0][15:0] raw;
		int                        target;
		int                        pick;
		reg_idx_t                  idx;
		logic [15:0]               v;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_BYTE;
		rx_byte <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;

		// The copy starts where the block comes out of reset.
		lost_after = RST_TIMEOUT_LIMIT;
		want_length = RST_LENGTH_BYTE;
		want_command = RST_COMMAND_BYTE;
		frame_pos = '0;
		byte_sum = '0;
		low_half = '0;
		frame_good = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			staged_chan[s] = '0;
			live_chan[s] = '0;
		end
		tick_count = '0;
		link_lost = 1'b0;
		cmd_one_now = '0;
		cmd_two_now = '0;
		switch_now = '0;
		words_sent = 0;
		mismatches = 0;
		cycles = 0;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan. First the state straight after reset: a tick with no frame yet, the
		// unused func value and an idle mark that closes an empty burst.
		add_step(STEP_WORD, FUNC_TICK, 16'h00, FLAW_NONE, 1'b1, AT_RESET);
		add_step(STEP_WORD, FUNC_UNUSED, 16'hFF, FLAW_NONE, 1'b1, AT_RESET);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00, FLAW_NONE, 1'b1, AT_RESET);
		// Full scale, then the bottom of the range: the commands only move on the tick.
		add_step(STEP_FRAME, 2'd0, 16'd2000);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00, FLAW_NONE, 1'b1, FIRST_FRAME_IN);
		add_step(STEP_WORD, FUNC_TICK, 16'h00, FLAW_NONE, 1'b1, FULL_SCALE);
		add_step(STEP_FRAME, 2'd0, 16'd1000);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00, FLAW_NONE, 1'b1, FULL_HELD_IN);
		add_step(STEP_WORD, FUNC_TICK, 16'h00, FLAW_NONE, 1'b1, AT_RESET);
		// Readings beyond either clamp limit.
		add_step(STEP_FRAME, 2'd0, 16'd0);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_WORD, FUNC_TICK, 16'h00);
		add_step(STEP_FRAME, 2'd0, 16'hFFFF);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_WORD, FUNC_TICK, 16'h00);
		// Frames that must be turned away: bad checksum, either header byte wrong, too short,
		// and too long (far enough past the end to pin the byte count at its ceiling).
		add_step(STEP_FRAME, 2'd0, 16'd1500, FLAW_CHECKSUM);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_FRAME, 2'd0, 16'd1500, FLAW_HEADER);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_FRAME, 2'd0, 16'd1500, FLAW_COMMAND);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_FRAME, 2'd0, 16'd1500, FLAW_SHORT);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_FRAME, 2'd0, 16'd1500, FLAW_LONG);
		repeat (32)
			add_step(STEP_WORD, FUNC_BYTE, 16'h5A);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_WORD, FUNC_BYTE, 16'h00);
		add_step(STEP_WORD, FUNC_BYTE, 16'hFF);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		// A short timeout runs out, and a good frame brings the link back.
		add_step(STEP_CFG, REG_TIMEOUT_LIMIT, 16'd2);
		repeat (4)
			add_step(STEP_WORD, FUNC_TICK, 16'h00);
		add_step(STEP_FRAME, 2'd0, 16'd1851);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_WORD, FUNC_TICK, 16'h00);
		// The limit dropped below the count already reached: the next tick times out at once.
		add_step(STEP_CFG, REG_TIMEOUT_LIMIT, 16'hFFFF);
		repeat (3)
			add_step(STEP_WORD, FUNC_TICK, 16'h00);
		add_step(STEP_CFG, REG_TIMEOUT_LIMIT, 16'd0);
		add_step(STEP_WORD, FUNC_TICK, 16'h00);
		// Header bytes at both extremes, with readings either side of the middle threshold.
		add_step(STEP_CFG, REG_LENGTH_BYTE, 16'hFF);
		add_step(STEP_CFG, REG_COMMAND_BYTE, 16'h00);
		add_step(STEP_FRAME, 2'd0, 16'd1251);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_WORD, FUNC_TICK, 16'h00);
		add_step(STEP_CFG, REG_LENGTH_BYTE, 16'h00);
		add_step(STEP_CFG, REG_COMMAND_BYTE, 16'hFF);
		add_step(STEP_FRAME, 2'd0, 16'd1250);
		add_step(STEP_WORD, FUNC_IDLE, 16'h00);
		add_step(STEP_WORD, FUNC_TICK, 16'h00);
		add_step(STEP_CFG, REG_TIMEOUT_LIMIT, RST_TIMEOUT_LIMIT);
		add_step(STEP_CFG, REG_LENGTH_BYTE, 16'(RST_LENGTH_BYTE));
		add_step(STEP_CFG, REG_COMMAND_BYTE, 16'(RST_COMMAND_BYTE));

		foreach (dir_plan[i]) begin
			case (dir_plan[i].kind)
				STEP_WORD: send_word(dir_plan[i].code, dir_plan[i].value[7:0],
					dir_plan[i].typed, dir_plan[i].want);
				STEP_FRAME: begin
					raw = {CHANNELS{dir_plan[i].value}};
					send_frame(raw, dir_plan[i].flaw);
				end
				default: write_register(reg_idx_t'(dir_plan[i].code), dir_plan[i].value);
			endcase
		end

		// Random part. Most of it is well-formed frames with random readings, closed by an idle
		// mark and followed by a few ticks; the rest is spoilt frames, loose bursts of bytes,
		// runs of ticks long enough to time out under a small limit, stray words of any func,
		// and now and then a new register setting.
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				for (int c = 0; c < CHANNELS; c++)
					raw[c] = random_raw();
				send_frame(raw, FLAW_NONE);
				send_word(FUNC_IDLE, 8'($urandom));
				repeat ($urandom_range(0, 3))
					send_word(FUNC_TICK, 8'($urandom));
			end else if (pick < 55) begin
				for (int c = 0; c < CHANNELS; c++)
					raw[c] = random_raw();
				send_frame(raw, frame_flaw_t'($urandom_range(FLAW_HEADER, FLAW_LONG)));
				send_word(FUNC_IDLE, 8'($urandom));
			end else if (pick < 63) begin
				repeat ($urandom_range(0, 40))
					send_word(FUNC_BYTE, 8'($urandom));
				send_word(FUNC_IDLE, 8'($urandom));
			end else if (pick < 80) begin
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 4))
					send_word(FUNC_TICK, 8'($urandom));
			end else if (pick < 92) begin
				send_word(2'($urandom), 8'($urandom));
			end else begin
				// Extremes, small limits that time out quickly, and fully random values.
				idx = reg_idx_t'($urandom_range(0, 2));
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = '1;
					2: v = 16'($urandom_range(1, 12));
					default: v = 16'($urandom);
				endcase
				if (idx != REG_TIMEOUT_LIMIT)
					v[15:8] = '0;
				write_register(idx, v);
			end
		end

		// Let every outstanding result word come back, then give the block time to show any
		// word it should not produce.
		drain_results();
		if (mismatches == 0 && status_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
